FILE: hw/rtl/centered_window_count_sum_top_defines.svh
// assertion macros for the centered window count sum block
// expects clk and rst_n in the scope of use
`ifndef CENTERED_WINDOW_COUNT_SUM_TOP_DEFINES_SVH
`define CENTERED_WINDOW_COUNT_SUM_TOP_DEFINES_SVH

// condition holds at every clock edge out of reset
`define CWCS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CWCS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/cwcs_pkg.sv
// shared widths, types and saturating helpers for the centered window count sum block
// no dependencies
package cwcs_pkg;

    localparam int MAX_WINDOW_DEF = 256;
    localparam int CFG_W          = 9;
    localparam int POS_W          = 32;
    localparam int CNT_W          = 20;
    localparam int SUM_W          = 28;
    localparam int NUM_CNT        = 4;

    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef cnt_t [NUM_CNT-1:0] cnt_vec_t;
    typedef sum_t [NUM_CNT-1:0] sum_vec_t;

    localparam sum_t SUM_MAX = '1;

    // add with hold at the top of the range
    function automatic sum_t sat_add(input sum_t a, input cnt_t b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W + 1 - CNT_W){1'b0}}, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    // subtract with hold at zero
    function automatic sum_t sat_sub(input sum_t a, input cnt_t b);
        logic [SUM_W:0] d;
        d = {1'b0, a} - {{(SUM_W + 1 - CNT_W){1'b0}}, b};
        return d[SUM_W] ? '0 : d[SUM_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/cwcs_site_if.sv
// site input channel: valid, ready and one site word
// depends on cwcs_pkg
interface cwcs_site_if;
    logic                        valid;
    logic                        ready;
    logic                        strand;
    logic [cwcs_pkg::POS_W-1:0]  site_pos;
    logic [cwcs_pkg::CNT_W-1:0]  factor_depth;
    logic [cwcs_pkg::CNT_W-1:0]  factor_muts;
    logic [cwcs_pkg::CNT_W-1:0]  mock_depth;
    logic [cwcs_pkg::CNT_W-1:0]  mock_muts;

    modport source (
        output valid, strand, site_pos, factor_depth, factor_muts, mock_depth, mock_muts,
        input  ready
    );
    modport sink (
        input  valid, strand, site_pos, factor_depth, factor_muts, mock_depth, mock_muts,
        output ready
    );
endinterface

FILE: hw/rtl/cwcs_win_if.sv
// window result channel: valid, ready and one window word
// depends on cwcs_pkg
interface cwcs_win_if;
    logic                        valid;
    logic                        ready;
    logic                        out_strand;
    logic [cwcs_pkg::POS_W-1:0]  center_pos;
    logic [cwcs_pkg::SUM_W-1:0]  sum_factor_depth;
    logic [cwcs_pkg::SUM_W-1:0]  sum_factor_muts;
    logic [cwcs_pkg::SUM_W-1:0]  sum_mock_depth;
    logic [cwcs_pkg::SUM_W-1:0]  sum_mock_muts;

    modport source (
        output valid, out_strand, center_pos, sum_factor_depth, sum_factor_muts,
               sum_mock_depth, sum_mock_muts,
        input  ready
    );
    modport sink (
        input  valid, out_strand, center_pos, sum_factor_depth, sum_factor_muts,
               sum_mock_depth, sum_mock_muts,
        output ready
    );
endinterface

FILE: hw/rtl/cwcs_cfg_if.sv
// configuration write channel carrying the window size
// depends on cwcs_pkg
interface cwcs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [cwcs_pkg::CFG_W-1:0]  win_size;

    modport source (
        output valid, win_size,
        input  ready
    );
    modport sink (
        input  valid, win_size,
        output ready
    );
endinterface

FILE: hw/rtl/cwcs_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module cwcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/centered_window_count_sum_top.sv
// centered window count sum, top level
// depends on cwcs_pkg, cwcs_site_if, cwcs_win_if, cwcs_cfg_if, cwcs_ram and the defines header
// site_in takes one site word per cycle unless stalled: strand, position and four read counts
// each strand keeps a ring of the last win_size sites in two rams (positions, counts)
// once a strand's ring is full every site gives one word on win_out: the strand,
// the position of the window's middle site and the four saturating window sums
// the result word goes through the ram read stage and then the output register to win_out
// throughput: one site per cycle unless stalled, set by the single read port of each ring ram
// (middle position from one, oldest counts from the other)
// cfg sets win_size (0 acts as 1, above MAX_WINDOW acts as MAX_WINDOW) and
// restarts both strands; write it only while the block is idle, cfg.ready is always high
// reset: window of one, rings empty, sums zero; ring contents need no clearing
// when win_out stalls the result is held in the output register; sites that give no
// word still pass the ram read stage, and once one that gives a word reaches it
// site_in.ready drops until the held word is taken
`include "centered_window_count_sum_top_defines.svh"

module centered_window_count_sum_top #(
    parameter int MAX_WINDOW = cwcs_pkg::MAX_WINDOW_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cwcs_cfg_if.sink    cfg,
    cwcs_site_if.sink   site_in,
    cwcs_win_if.source  win_out
);

    localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WS_W       = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W     = IDX_W + 1;
    localparam int RING_DEPTH = 2 ** ADDR_W;
    localparam int CNTS_W     = cwcs_pkg::NUM_CNT * cwcs_pkg::CNT_W;

    // window configuration
    logic [WS_W-1:0]  ws_reg, ws_next;
    logic [IDX_W-1:0] ws_m1_reg, ws_m1_next;
    logic [IDX_W-1:0] half_reg, half_next;
    logic             cfg_we;

    // per strand ring pointers
    logic [IDX_W-1:0] head_reg [2];
    logic [IDX_W-1:0] tail_reg [2];
    logic [WS_W-1:0]  fill_reg [2];

    // issue stage
    logic                     acc;
    logic                     s0;
    logic [IDX_W-1:0]         head_cur, tail_cur, ins_idx, tail_new, mid_idx;
    logic [WS_W-1:0]          fill_cur, fill_new;
    logic [IDX_W:0]           mid_sum, ws_ext;
    logic                     emit0;
    cwcs_pkg::cnt_vec_t       in_cnt;

    // ram read stage
    logic                     s1_valid_reg, s1_valid_next;
    logic                     s1_emit_reg;
    logic                     s1_strand_reg;
    logic                     s1_fwd_mid_reg;
    logic                     s1_fwd_tail_reg;
    logic [cwcs_pkg::POS_W-1:0] s1_pos_reg;
    cwcs_pkg::cnt_vec_t       s1_cnt_reg;
    logic                     s1_adv;

    logic [cwcs_pkg::POS_W-1:0] pos_rdata, center_pos;
    logic [CNTS_W-1:0]        cnt_rdata;
    cwcs_pkg::cnt_vec_t       old_cnt;
    cwcs_pkg::sum_vec_t       sums_reg [2];
    cwcs_pkg::sum_vec_t       added, left;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic                     out_free, out_load;
    logic                     out_strand_reg;
    logic [cwcs_pkg::POS_W-1:0] out_pos_reg;
    cwcs_pkg::sum_vec_t       out_sums_reg;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    always_comb
    begin
        if (cfg.win_size == '0)
        begin
            ws_next = WS_W'(1);
        end
        else if (int'(cfg.win_size) > MAX_WINDOW)
        begin
            ws_next = WS_W'(MAX_WINDOW);
        end
        else
        begin
            ws_next = WS_W'(cfg.win_size);
        end
        ws_m1_next = IDX_W'(ws_next - WS_W'(1));
        half_next  = IDX_W'(ws_next >> 1);
    end

    // issue: pointer update, ring write and reads of middle and oldest slots
    assign acc    = site_in.valid && site_in.ready;
    assign s0     = site_in.strand;
    assign in_cnt = {site_in.mock_muts, site_in.mock_depth,
                     site_in.factor_muts, site_in.factor_depth};

    always_comb
    begin
        head_cur = head_reg[s0];
        tail_cur = tail_reg[s0];
        fill_cur = fill_reg[s0];
        ins_idx  = (head_cur == ws_m1_reg) ? '0 : head_cur + IDX_W'(1);
        tail_new = (tail_cur == ws_m1_reg) ? '0 : tail_cur + IDX_W'(1);
        fill_new = (fill_cur < ws_reg) ? fill_cur + WS_W'(1) : fill_cur;
        emit0    = (fill_new == ws_reg);
        ws_ext   = (IDX_W + 1)'(ws_reg);
        mid_sum  = {1'b0, tail_new} + {1'b0, half_reg};
        mid_idx  = (mid_sum >= ws_ext) ? IDX_W'(mid_sum - ws_ext) : IDX_W'(mid_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg      <= WS_W'(1);
            ws_m1_reg   <= '0;
            half_reg    <= '0;
            head_reg[0] <= '0;
            head_reg[1] <= '0;
            tail_reg[0] <= '0;
            tail_reg[1] <= '0;
            fill_reg[0] <= '0;
            fill_reg[1] <= '0;
        end
        else if (cfg_we)
        begin
            ws_reg      <= ws_next;
            ws_m1_reg   <= ws_m1_next;
            half_reg    <= half_next;
            head_reg[0] <= ws_m1_next;
            head_reg[1] <= ws_m1_next;
            tail_reg[0] <= ws_m1_next;
            tail_reg[1] <= ws_m1_next;
            fill_reg[0] <= '0;
            fill_reg[1] <= '0;
        end
        else if (acc)
        begin
            head_reg[s0] <= ins_idx;
            fill_reg[s0] <= fill_new;
            if (emit0)
            begin
                tail_reg[s0] <= tail_new;
            end
        end
    end

    cwcs_ram #(
        .WIDTH (cwcs_pkg::POS_W),
        .DEPTH (RING_DEPTH)
    ) u_pos_ram (
        .clk   (clk),
        .we    (acc),
        .waddr ({s0, ins_idx}),
        .wdata (site_in.site_pos),
        .re    (acc),
        .raddr ({s0, mid_idx}),
        .rdata (pos_rdata)
    );

    cwcs_ram #(
        .WIDTH (CNTS_W),
        .DEPTH (RING_DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (acc),
        .waddr ({s0, ins_idx}),
        .wdata (in_cnt),
        .re    (acc),
        .raddr ({s0, tail_new}),
        .rdata (cnt_rdata)
    );

    // read stage: sums read, add new site, emit, drop oldest
    assign out_free = !out_valid_reg || win_out.ready;
    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || out_free);
    assign out_load = s1_adv && s1_emit_reg;
    assign site_in.ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        if (acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (acc)
            begin
                s1_emit_reg <= emit0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_strand_reg   <= s0;
            s1_pos_reg      <= site_in.site_pos;
            s1_cnt_reg      <= in_cnt;
            s1_fwd_mid_reg  <= (mid_idx == ins_idx);
            s1_fwd_tail_reg <= (tail_new == ins_idx);
        end
    end

    // slot written by this same site is forwarded past the ram
    assign center_pos = s1_fwd_mid_reg ? s1_pos_reg : pos_rdata;
    assign old_cnt    = s1_fwd_tail_reg ? s1_cnt_reg : cwcs_pkg::cnt_vec_t'(cnt_rdata);

    always_comb
    begin
        for (int j = 0; j < cwcs_pkg::NUM_CNT; j++)
        begin
            added[j] = cwcs_pkg::sat_add(sums_reg[s1_strand_reg][j], s1_cnt_reg[j]);
            left[j]  = s1_emit_reg ? cwcs_pkg::sat_sub(added[j], old_cnt[j]) : added[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sums_reg[0] <= '0;
            sums_reg[1] <= '0;
        end
        else if (cfg_we)
        begin
            sums_reg[0] <= '0;
            sums_reg[1] <= '0;
        end
        else if (s1_adv)
        begin
            sums_reg[s1_strand_reg] <= left;
        end
    end

    // output register
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (win_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_strand_reg <= s1_strand_reg;
            out_pos_reg    <= center_pos;
            out_sums_reg   <= added;
        end
    end

    assign win_out.valid            = out_valid_reg;
    assign win_out.out_strand       = out_strand_reg;
    assign win_out.center_pos       = out_pos_reg;
    assign win_out.sum_factor_depth = out_sums_reg[0];
    assign win_out.sum_factor_muts  = out_sums_reg[1];
    assign win_out.sum_mock_depth   = out_sums_reg[2];
    assign win_out.sum_mock_muts    = out_sums_reg[3];

    `CWCS_ASSERT_ALWAYS(a_fill_bound, fill_reg[0] <= ws_reg && fill_reg[1] <= ws_reg, "fill")
    `CWCS_ASSERT_ALWAYS(a_head_bound, head_reg[0] <= ws_m1_reg && head_reg[1] <= ws_m1_reg, "head")
    `CWCS_ASSERT_IMPL(a_emit_full, s1_valid_reg && s1_emit_reg, fill_reg[s1_strand_reg] == ws_reg, "emit")
    `CWCS_ASSERT_IMPL(a_no_overrun, out_valid_reg && !win_out.ready, !out_load, "held word overwritten")

endmodule
